FILE: hdl/nmeacs_pkg.sv
// Shared types, character constants and the sentence prefix table for the NMEA checksum checker.
`default_nettype none

package nmeacs_pkg;

    typedef logic [7:0] char_t;

    localparam int LINE_BUFFER_BYTES_DEF = 128;

    localparam char_t START_MARK = 8'h24;
    localparam char_t STAR_MARK  = 8'h2A;
    localparam char_t NEWLINE    = 8'h0A;
    localparam char_t NUL_CHAR   = 8'h00;
    localparam char_t STAR_LIMIT = 8'd75;
    localparam char_t PREFIX_END = 8'd6;

    localparam int KIND_COUNT = 4;
    localparam int PREFIX_LEN = 6;

    localparam char_t KIND_PREFIX [KIND_COUNT][PREFIX_LEN] = '{
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
        '{8'h24, 8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},
        '{8'h24, 8'h47, 8'h50, 8'h47, 8'h4C, 8'h4C},
        '{8'h24, 8'h47, 8'h50, 8'h56, 8'h54, 8'h47}
    };

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_GPGGA = 3'd1,
        KIND_GNRMC = 3'd2,
        KIND_GPGLL = 3'd3,
        KIND_GPVTG = 3'd4
    } kind_t;

    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_SUM   = 6'b000010,
        PH_HEX1  = 6'b000100,
        PH_HEX2  = 6'b001000,
        PH_OK    = 6'b010000,
        PH_BAD   = 6'b100000
    } phase_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
        char_t sum;
    } verdict_t;

    function automatic char_t hex_digit(input logic [3:0] nib);
        char_t wide;
        begin
            wide = {4'b0000, nib};
            if (nib < 4'd10)
            begin
                hex_digit = 8'h30 + wide;
            end
            else
            begin
                hex_digit = 8'h41 + wide - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/nmeacs_line.sv
// Line framing, running XOR, checksum compare and sentence kind tracking for one byte per cycle while take is high.
`default_nettype none

module nmeacs_line #(
    parameter int LINE_BUFFER_BYTES = nmeacs_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire nmeacs_pkg::char_t  data,
    output logic                    line_end,
    output nmeacs_pkg::verdict_t    verdict
);
    import nmeacs_pkg::*;

    localparam char_t BUF_LIMIT = char_t'(LINE_BUFFER_BYTES);

    phase_t                phase_reg, phase_next;
    char_t                 pos_reg, pos_next;
    char_t                 sum_reg, sum_next;
    char_t                 hex1_reg, hex1_next;
    logic [KIND_COUNT-1:0] flags_reg, flags_next;

    assign line_end = (data == NEWLINE) || (pos_reg >= BUF_LIMIT);

    always_comb
    begin
        verdict.valid = (phase_reg == PH_OK);
        verdict.sum   = sum_reg;
        verdict.kind  = KIND_NONE;
        if (verdict.valid && (pos_reg >= PREFIX_END))
        begin
            if (flags_reg[0])
            begin
                verdict.kind = KIND_GPGGA;
            end
            else if (flags_reg[1])
            begin
                verdict.kind = KIND_GNRMC;
            end
            else if (flags_reg[2])
            begin
                verdict.kind = KIND_GPGLL;
            end
            else if (flags_reg[3])
            begin
                verdict.kind = KIND_GPVTG;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        hex1_next  = hex1_reg;
        flags_next = flags_reg;
        if (line_end)
        begin
            phase_next = PH_START;
            pos_next   = '0;
            sum_next   = '0;
            hex1_next  = '0;
            flags_next = '1;
        end
        else
        begin
            pos_next = pos_reg + 8'd1;
            if (pos_reg < PREFIX_END)
            begin
                for (int k = 0; k < KIND_COUNT; k++)
                begin
                    if (data != KIND_PREFIX[k][pos_reg[2:0]])
                    begin
                        flags_next[k] = 1'b0;
                    end
                end
            end
            case (phase_reg)
                PH_START:
                begin
                    phase_next = (data == START_MARK) ? PH_SUM : PH_BAD;
                end
                PH_SUM:
                begin
                    if ((pos_reg >= STAR_LIMIT) || (data == NUL_CHAR))
                    begin
                        phase_next = PH_BAD;
                    end
                    else if (data == STAR_MARK)
                    begin
                        phase_next = PH_HEX1;
                    end
                    else
                    begin
                        sum_next = sum_reg ^ data;
                    end
                end
                PH_HEX1:
                begin
                    hex1_next  = data;
                    phase_next = PH_HEX2;
                end
                PH_HEX2:
                begin
                    phase_next = ((hex1_reg == hex_digit(sum_reg[7:4])) &&
                                  (data == hex_digit(sum_reg[3:0]))) ? PH_OK : PH_BAD;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            pos_reg   <= '0;
            sum_reg   <= '0;
            hex1_reg  <= '0;
            flags_reg <= '1;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
            hex1_reg  <= hex1_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/nmea_sentence_checksum_checker.sv
// Top level of the NMEA 0183 sentence checksum checker: input register, line tracker, result register.
//
// Input channel: one received byte per request on rx_byte with in_valid/in_stall.
// A newline byte ends the line; so does any byte arriving while LINE_BUFFER_BYTES
// bytes are already held, and that byte is dropped. Other bytes give no result.
// Output channel: one verdict request per line end on sentence_valid, sentence_kind
// and computed_sum with out_valid/out_stall.
// A line-end byte passes the input register and then the result register before its
// verdict can be taken at the output. Throughput: one byte per cycle while no line-end
// byte is stalled, set by the line tracker's state update between the input and result registers.
// Stall: a held result blocks only a following line-end byte; ordinary bytes
// keep flowing into the line state. in_stall rises when a line-end byte sits
// in the input register while the result register is full and stalled.
// Reset: clears both registers' valid flags and returns the line state to
// waiting for the start mark with an empty line.
`default_nettype none

module nmea_sentence_checksum_checker #(
    parameter int LINE_BUFFER_BYTES = nmeacs_pkg::LINE_BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire nmeacs_pkg::char_t  rx_byte,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    sentence_valid,
    output logic [2:0]              sentence_kind,
    output nmeacs_pkg::char_t       computed_sum
);
    import nmeacs_pkg::*;

    logic     s1_valid_reg, s1_valid_next;
    char_t    s1_byte_reg;
    logic     out_valid_reg, out_valid_next;
    verdict_t result_reg;
    logic     line_end;
    logic     go;
    logic     accept;
    verdict_t verdict;

    nmeacs_line #(
        .LINE_BUFFER_BYTES(LINE_BUFFER_BYTES)
    ) u_line (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (go),
        .data     (s1_byte_reg),
        .line_end (line_end),
        .verdict  (verdict)
    );

    assign go       = s1_valid_reg && (!line_end || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !go;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (go && line_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= rx_byte;
        end
        if (go && line_end)
        begin
            result_reg <= verdict;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sentence_valid = result_reg.valid;
    assign sentence_kind  = result_reg.kind;
    assign computed_sum   = result_reg.sum;

endmodule

`default_nettype wire

FILE: hdl/nmeacs_checker.sv
// Port-level checks for the NMEA checksum checker, bound to its top level.
`default_nettype none

module nmeacs_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic       sentence_valid,
    input wire logic [2:0] sentence_kind,
    input wire logic [7:0] computed_sum
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sentence_valid) &&
        $stable(sentence_kind) && $stable(computed_sum))
        else $error("stalled result changed");

    a_kind_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (sentence_kind != 3'd0) |-> sentence_valid)
        else $error("sentence kind reported on a failed line");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (sentence_kind == 3'd0) || (sentence_kind == 3'd1) ||
        (sentence_kind == 3'd2) || (sentence_kind == 3'd3) || (sentence_kind == 3'd4))
        else $error("sentence kind out of range");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind nmea_sentence_checksum_checker nmeacs_checker u_nmeacs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sentence_valid (sentence_valid),
    .sentence_kind  (sentence_kind),
    .computed_sum   (computed_sum)
);

`default_nettype wire

FILE: tb/testbench.sv
// Testbench for the NMEA sentence checksum checker: byte driver, verdict monitor, line predictor.
module testbench;
    import nmeacs_pkg::*;

    typedef enum int {
        LINE_GOOD,
        LINE_BAD_SUM,
        LINE_LOWER_HEX,
        LINE_CUT,
        LINE_NUL,
        LINE_LATE_STAR,
        LINE_NO_START,
        LINE_NOISE,
        LINE_OVERFLOW
    } line_shape_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    char_t      rx_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       sentence_valid;
    logic [2:0] sentence_kind;
    char_t      computed_sum;

    char_t      byte_q[$];
    verdict_t   verdict_q[$];
    verdict_t   next_verdict;
    verdict_t   want;
    int         line_total = 0;
    int         bytes_total = 0;
    int         bytes_taken = 0;
    int         hold_mark = 0;
    int         error_count = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         hold_left = 0;
    logic       quiet = 1'b0;
    int         quiet_left = 100;

    phase_t     ln_phase = PH_START;
    logic [7:0] ln_pos = '0;
    char_t      ln_sum = '0;
    char_t      ln_hex1 = '0;
    logic [3:0] ln_kinds = 4'hF;

    nmea_sentence_checksum_checker dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .sentence_valid (sentence_valid),
        .sentence_kind  (sentence_kind),
        .computed_sum   (computed_sum)
    );

    function automatic char_t hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + {4'h0, n};
        end
        return 8'h37 + {4'h0, n};
    endfunction

    function automatic bit predict_byte(input char_t b, output verdict_t v);
        v = '0;
        if (b != NEWLINE && ln_pos < LINE_BUFFER_BYTES_DEF)
        begin
            if (ln_pos < PREFIX_END)
            begin
                for (int k = 0; k < KIND_COUNT; k++)
                begin
                    if (b != KIND_PREFIX[k][ln_pos])
                    begin
                        ln_kinds[k] = 1'b0;
                    end
                end
            end
            case (ln_phase)
                PH_START:
                begin
                    ln_phase = (b == START_MARK) ? PH_SUM : PH_BAD;
                end
                PH_SUM:
                begin
                    if (ln_pos >= STAR_LIMIT || b == NUL_CHAR)
                    begin
                        ln_phase = PH_BAD;
                    end
                    else if (b == STAR_MARK)
                    begin
                        ln_phase = PH_HEX1;
                    end
                    else
                    begin
                        ln_sum = ln_sum ^ b;
                    end
                end
                PH_HEX1:
                begin
                    ln_hex1 = b;
                    ln_phase = PH_HEX2;
                end
                PH_HEX2:
                begin
                    ln_phase = (ln_hex1 == hex_char(ln_sum[7:4]) && b == hex_char(ln_sum[3:0]))
                               ? PH_OK : PH_BAD;
                end
                default:
                begin
                end
            endcase
            ln_pos = ln_pos + 8'd1;
            return 1'b0;
        end
        v.valid = (ln_phase == PH_OK);
        v.kind = KIND_NONE;
        v.sum = ln_sum;
        if (v.valid && ln_pos >= PREFIX_END)
        begin
            for (int k = KIND_COUNT - 1; k >= 0; k--)
            begin
                if (ln_kinds[k])
                begin
                    v.kind = kind_t'(k + 1);
                end
            end
        end
        ln_phase = PH_START;
        ln_pos = '0;
        ln_sum = '0;
        ln_hex1 = '0;
        ln_kinds = 4'hF;
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 98)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic char_t body_char();
        char_t c;
        if ($urandom_range(0, 7) == 0)
        begin
            c = char_t'($urandom_range(128, 255));
        end
        else
        begin
            c = char_t'($urandom_range(32, 126));
        end
        if (c == STAR_MARK)
        begin
            c = 8'h2C;
        end
        return c;
    endfunction

    task automatic add_sentence(input line_shape_t shape, input int kind_pick, input int body_len);
        char_t body[$];
        char_t line[$];
        char_t sum;
        char_t hi;
        char_t lo;
        char_t c;
        int    cut_at;
        sum = '0;
        line_total++;
        if (shape == LINE_NOISE)
        begin
            repeat (body_len) byte_q.push_back(char_t'($urandom_range(0, 255)));
            byte_q.push_back(NEWLINE);
            return;
        end
        if (shape == LINE_OVERFLOW)
        begin
            byte_q.push_back(START_MARK);
            repeat (body_len - 1)
            begin
                c = char_t'($urandom_range(0, 255));
                byte_q.push_back((c == NEWLINE) ? 8'h0B : c);
            end
            byte_q.push_back(NEWLINE);
            return;
        end
        if (kind_pick < KIND_COUNT)
        begin
            for (int i = 1; i < PREFIX_LEN; i++)
            begin
                body.push_back(KIND_PREFIX[kind_pick][i]);
            end
        end
        repeat (body_len) body.push_back(body_char());
        if (shape == LINE_NUL)
        begin
            body.insert($urandom_range(0, body.size()), NUL_CHAR);
        end
        foreach (body[i])
        begin
            sum = sum ^ body[i];
        end
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (shape == LINE_BAD_SUM)
        begin
            if ($urandom_range(0, 1))
            begin
                lo = lo ^ 8'h01;
            end
            else
            begin
                hi = hi ^ 8'h01;
            end
        end
        if (shape == LINE_LOWER_HEX)
        begin
            hi = (hi > 8'h40) ? (hi | 8'h20) : hi;
            lo = (lo > 8'h40) ? (lo | 8'h20) : lo;
        end
        if (shape == LINE_NO_START)
        begin
            c = body_char();
            line.push_back((c == START_MARK) ? 8'h23 : c);
        end
        else
        begin
            line.push_back(START_MARK);
        end
        foreach (body[i])
        begin
            line.push_back(body[i]);
        end
        line.push_back(STAR_MARK);
        line.push_back(hi);
        line.push_back(lo);
        if (shape == LINE_GOOD && $urandom_range(0, 2) == 0)
        begin
            line.push_back(8'h0D);
            line.push_back(body_char());
        end
        if (shape == LINE_CUT)
        begin
            cut_at = $urandom_range(1, line.size() - 1);
            while (line.size() > cut_at)
            begin
                void'(line.pop_back());
            end
        end
        foreach (line[i])
        begin
            byte_q.push_back(line[i]);
        end
        byte_q.push_back(NEWLINE);
    endtask

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet <= 1'b0;
            quiet_left <= 100;
        end
        else if (quiet_left == 0)
        begin
            quiet <= ~quiet;
            quiet_left <= $urandom_range(50, 400);
        end
        else
        begin
            quiet_left <= quiet_left - 1;
        end
    end

    // hold off long at two points to back up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_mark <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                hold_mark <= hold_mark + 1;
            end
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (out_valid && !out_stall && (hold_mark == 11 || hold_mark == 29))
            begin
                hold_left <= 300;
            end
        end
    end

    // drive one byte request at a time; hold while stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            rx_byte <= '0;
            send_gap <= 0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                bytes_taken++;
                if (predict_byte(rx_byte, next_verdict))
                begin
                    verdict_q.push_back(next_verdict);
                end
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                in_valid <= 1'b1;
                rx_byte <= byte_q.pop_front();
                send_gap <= quiet ? 0 : pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // check each verdict request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict with none pending: valid %0d kind %0d sum %0h",
                           sentence_valid, sentence_kind, computed_sum);
                    error_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (sentence_valid !== want.valid)
                    begin
                        $error("sentence_valid: expected %0d, actual %0d",
                               want.valid, sentence_valid);
                        error_count++;
                    end
                    if (sentence_kind !== want.kind)
                    begin
                        $error("sentence_kind: expected %0d, actual %0d",
                               want.kind, sentence_kind);
                        error_count++;
                    end
                    if (computed_sum !== want.sum)
                    begin
                        $error("computed_sum: expected %0h, actual %0h",
                               want.sum, computed_sum);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                recv_gap <= quiet ? 0 : pick_gap();
            end
        end
    end

    initial
    begin
        #12000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int          r;
        line_shape_t shape;
        rst_n = 1'b0;

        byte_q.push_back(NEWLINE);
        line_total++;
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            add_sentence(LINE_GOOD, k, 6);
        end
        add_sentence(LINE_GOOD, KIND_COUNT, 0);
        add_sentence(LINE_GOOD, KIND_COUNT, 12);
        add_sentence(LINE_BAD_SUM, 0, 4);
        add_sentence(LINE_LOWER_HEX, 1, 8);
        add_sentence(LINE_CUT, 2, 3);
        add_sentence(LINE_NUL, 3, 5);
        add_sentence(LINE_LATE_STAR, 0, 80);
        add_sentence(LINE_NO_START, 0, 6);
        byte_q.push_back(8'h00);
        byte_q.push_back(8'hFF);
        byte_q.push_back(NEWLINE);
        line_total++;
        add_sentence(LINE_OVERFLOW, 0, LINE_BUFFER_BYTES_DEF);
        add_sentence(LINE_OVERFLOW, 0, LINE_BUFFER_BYTES_DEF + 3);

        while (byte_q.size() < 1000)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                shape = LINE_GOOD;
            end
            else if (r < 63)
            begin
                shape = LINE_BAD_SUM;
            end
            else if (r < 67)
            begin
                shape = LINE_LOWER_HEX;
            end
            else if (r < 74)
            begin
                shape = LINE_CUT;
            end
            else if (r < 79)
            begin
                shape = LINE_NUL;
            end
            else if (r < 83)
            begin
                shape = LINE_LATE_STAR;
            end
            else if (r < 88)
            begin
                shape = LINE_NO_START;
            end
            else if (r < 96)
            begin
                shape = LINE_NOISE;
            end
            else
            begin
                shape = LINE_OVERFLOW;
            end
            case (shape)
                LINE_LATE_STAR: add_sentence(shape, $urandom_range(0, 5), $urandom_range(70, 90));
                LINE_OVERFLOW:  add_sentence(shape, 0, $urandom_range(120, 140));
                LINE_NOISE:     add_sentence(shape, 0, $urandom_range(1, 30));
                default:        add_sentence(shape, $urandom_range(0, 5), $urandom_range(0, 24));
            endcase
        end
        bytes_total = byte_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_taken < bytes_total || verdict_q.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (error_count == 0 && verdict_q.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
